// File: src/pcl_pkg.sv
`timescale 1ns / 1ps
// Package for the positional circular list: command, status and shift codes,
// and the control bundle broadcast to every storage cell. No dependencies.
package pcl_pkg;

	localparam int ValueW = 32;
	localparam int PosW   = 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_POS  = 2'd1,
		ST_FULL = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_UP   = 2'd1,
		SH_DOWN = 2'd2
	} shift_e_t;

	// One broadcast per accepted beat: what the row of cells does this cycle.
	typedef struct packed {
		shift_e_t                  op;
		logic [PosW-1:0]           pos_idx;
		logic signed [ValueW-1:0]  value;
	} cell_ctl_t;

endpackage

// File: src/pcl_cell.sv
`timescale 1ns / 1ps
// One storage cell of the positional list: holds one entry and trades it with
// its neighbors on insert and remove. Depends on pcl_pkg.
module pcl_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  pcl_pkg::cell_ctl_t                 ctl,
	input  logic signed [pcl_pkg::ValueW-1:0]  prev_entry,
	input  logic signed [pcl_pkg::ValueW-1:0]  next_entry,
	output logic signed [pcl_pkg::ValueW-1:0]  entry,
	output logic signed [pcl_pkg::ValueW-1:0]  rd_data
);
	import pcl_pkg::*;

	localparam logic [PosW-1:0] Idx = PosW'(IDX);

	logic signed [ValueW-1:0] entry_q;
	logic                     hit;
	logic                     above;

	assign hit   = (Idx == ctl.pos_idx);
	assign above = (Idx > ctl.pos_idx);

	// Entries carry no reset; only positions below the count are ever read.
	always_ff @(posedge clk) begin
		case (ctl.op)
			SH_UP: begin
				if (hit) begin
					entry_q <= ctl.value;
				end else if (above) begin
					entry_q <= prev_entry;
				end
			end
			SH_DOWN: begin
				if (hit || above) begin
					entry_q <= next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry   = entry_q;
	assign rd_data = hit ? entry_q : '0;

endmodule

// File: src/positional_circular_list_top.sv
`timescale 1ns / 1ps
// Top level of the positional circular list: command decode, entry count,
// result register and the row of pcl_cell storage cells. Depends on pcl_pkg.
//
//   Channel | Handshake          | Beat contents
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_ready  | cmd, position, value
//   out     | out_valid/out_ready| read_value, count, is_empty, status
//
// On every accepted command all cells shift, load or hold in parallel
// at the accepting edge, and the result sits in the output register from the
// next cycle on. A new beat is taken whenever the output register is empty
// or is being drained in the same cycle, so a full rate of one beat per
// cycle holds while out_ready stays high. Reset clears the count and the
// output valid; cell contents are not reset and need no clearing pass.
// A stall on the output simply holds in_ready low until the result is taken.
module positional_circular_list_top #(
	parameter int CAPACITY = 64,
	localparam int CountW  = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         cmd,
	input  logic [pcl_pkg::PosW-1:0]           position,
	input  logic signed [pcl_pkg::ValueW-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pcl_pkg::ValueW-1:0]  read_value,
	output logic [CountW-1:0]                  count,
	output logic                               is_empty,
	output logic [1:0]                         status
);
	import pcl_pkg::*;

	logic [CountW-1:0]        cnt_q;
	logic                     out_valid_q;
	logic signed [ValueW-1:0] rv_q;
	status_e_t                st_q;

	logic                     accept;
	logic [PosW:0]            pos_ext;
	logic [PosW:0]            cnt_ext;
	logic                     pos_nonzero;
	logic                     ins_pos_ok;
	logic                     rr_pos_ok;
	logic                     full;
	shift_e_t                 op;
	status_e_t                st_d;
	logic                     rd_sel;
	logic [CountW-1:0]        cnt_d;
	cell_ctl_t                ctl;
	logic signed [ValueW-1:0] rd_or;

	logic signed [ValueW-1:0] entry_w [CAPACITY];
	logic signed [ValueW-1:0] rd_w    [CAPACITY];

	// The output register frees up in the same cycle it is drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Position checks are made against the count before the command.
	assign pos_ext     = {1'b0, position};
	assign cnt_ext     = (PosW + 1)'(cnt_q);
	assign pos_nonzero = (position != '0);
	assign ins_pos_ok  = pos_nonzero && (pos_ext <= cnt_ext + 1'b1);
	assign rr_pos_ok   = pos_nonzero && (pos_ext <= cnt_ext);
	assign full        = (cnt_q == CountW'(CAPACITY));

	always_comb begin
		op     = SH_HOLD;
		st_d   = ST_OK;
		rd_sel = 1'b0;
		cnt_d  = cnt_q;
		case (cmd_e_t'(cmd))
			CMD_INSERT: begin
				if (!ins_pos_ok) begin
					st_d = ST_POS;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					op    = SH_UP;
					cnt_d = cnt_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!rr_pos_ok) begin
					st_d = ST_POS;
				end else begin
					op    = SH_DOWN;
					cnt_d = cnt_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (!rr_pos_ok) begin
					st_d = ST_POS;
				end else begin
					rd_sel = 1'b1;
				end
			end
			default: begin
				op = SH_HOLD;
			end
		endcase
	end

	// The row of cells only moves on an accepted beat.
	assign ctl.op      = accept ? op : SH_HOLD;
	assign ctl.pos_idx = position - 1'b1;
	assign ctl.value   = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ValueW-1:0] prev_w;
		logic signed [ValueW-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = value;
		end else begin : g_mid_lo
			assign prev_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_hi
			assign next_w = entry_w[i+1];
		end

		pcl_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (entry_w[i]),
			.rd_data    (rd_w[i])
		);
	end

	// At most one cell matches the position, so an OR merges the read taps.
	always_comb begin
		rd_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_or = rd_or | rd_w[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rv_q <= rd_sel ? rd_or : '0;
			st_q <= st_d;
		end
	end

	// Count only changes on an accept, so it can drive the result directly.
	assign out_valid  = out_valid_q;
	assign read_value = rv_q;
	assign count      = cnt_q;
	assign is_empty   = (cnt_q == '0);
	assign status     = st_q;

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) cnt_q <= CountW'(CAPACITY);
	endproperty
	a_cnt_bound: assert property (p_cnt_bound)
		else $error("entry count exceeds capacity");

	property p_cnt_stable;
		@(posedge clk) disable iff (!arst_n) !accept |=> $stable(cnt_q);
	endproperty
	a_cnt_stable: assert property (p_cnt_stable)
		else $error("entry count changed without an accepted beat");

	property p_result_follows;
		@(posedge clk) disable iff (!arst_n) accept |=> out_valid_q;
	endproperty
	a_result_follows: assert property (p_result_follows)
		else $error("accepted beat produced no result");

	property p_full_status;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && st_q == ST_FULL) |-> full;
	endproperty
	a_full_status: assert property (p_full_status)
		else $error("full status reported while not full");

	property p_err_zero;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && st_q != ST_OK) |-> (rv_q == '0);
	endproperty
	a_err_zero: assert property (p_err_zero)
		else $error("nonzero read value on an error result");

endmodule
